// ===== rtl/gated_decay_and_beta_gate_macros.svh =====
// Assertion macros for the decay and beta gate block.
`ifndef GATED_DECAY_AND_BETA_GATE_MACROS_SVH
`define GATED_DECAY_AND_BETA_GATE_MACROS_SVH
`ifndef ASSERT_OFF
`define GDBG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define GDBG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define GDBG_ASSERT(lbl, prop, msg)
`define GDBG_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/gdbg_pkg.sv =====
`timescale 1ns / 1ps
package gdbg_pkg;

  localparam int DW = 16;

  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [18:0] LOG2E_Q18 = 19'd378194;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  // 2^f Horner coefficients, Q.30
  localparam logic [31:0] PC1 = 32'd744261118;
  localparam logic [31:0] PC2 = 32'd257941248;
  localparam logic [31:0] PC3 = 32'd59597083;
  localparam logic [31:0] PC4 = 32'd10327388;
  localparam logic [31:0] PC5 = 32'd1431680;
  localparam logic [31:0] PC6 = 32'd165394;

  localparam int POW_LAT  = 6;
  localparam logic [31:0] POW_ADD [POW_LAT] = '{PC5, PC4, PC3, PC2, PC1, ONE_Q30};

  localparam int EXP_W    = 36;
  localparam int EXP_LAT  = POW_LAT + 2;
  localparam int LN_STEPS = 24;
  localparam int LN_LAT   = LN_STEPS + 2;
  localparam int QB       = 13;
  localparam int DIV_LAT  = QB + 1;

endpackage

// ===== rtl/gated_decay_and_beta_gate.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle while a full output buffer does not stall the pipeline; every
// stage holds at most one multiply or one compare-subtract on each path, and the ln(1+t)
// squaring chain (24 stages) sets the depth.
// A two-entry output buffer keeps the pipeline moving while one result waits.
// Reset (rst_ni low, async): clears valid bits, buffer count and byp_q (bypass mode).
`include "gated_decay_and_beta_gate_macros.svh"
module gated_decay_and_beta_gate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // gate_in[15:0], beta_in[31:16], time_bias[47:32], log_rate[63:48]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // decay[15:0], beta[31:16]
  output logic [31:0] m_axis_tdata
);

  localparam int DW     = gdbg_pkg::DW;
  localparam int T_T    = 2 + gdbg_pkg::EXP_LAT;
  localparam int T_LN   = T_T + gdbg_pkg::LN_LAT;
  localparam int T_SP   = T_LN + 1;
  localparam int T_R    = 2 + gdbg_pkg::POW_LAT + 1;
  localparam int T_P    = T_SP + 2;
  localparam int T_E    = T_P + 1 + gdbg_pkg::EXP_LAT;
  localparam int DEPTH  = T_E + 1;
  localparam int T_S    = T_T + gdbg_pkg::DIV_LAT;
  localparam int T_B    = T_S + 1;
  localparam int D_X    = T_LN - 1;
  localparam int D_R    = T_SP - T_R;
  localparam int D_BIG  = T_E - T_P;
  localparam int D_NEG  = T_S - 1;
  localparam int D_BETA = T_E - T_B;
  localparam int D_BYP  = T_E - 1;

  logic signed [DW-1:0] gate, bin, bias, lrate;
  assign gate  = s_axis_tdata[15:0];
  assign bin   = s_axis_tdata[31:16];
  assign bias  = s_axis_tdata[47:32];
  assign lrate = s_axis_tdata[63:48];

  logic             byp_q;
  logic [1:0]       cnt_q;
  logic [31:0]      ob_q [2];
  logic             en, push, pop;
  logic [DEPTH-1:0] vld_q;

  assign en            = (cnt_q != 2'd2) || m_axis_tready;
  assign s_axis_tready = en;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign push          = en && vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) byp_q <= cfg_wdata_i;
      if (en) vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // stage 1
  logic signed [16:0]   x1_q;
  logic signed [DW-1:0] a1_q, b1_q, lr1_q;
  logic                 byp1_q;

  // stage 2
  logic [16:0]        ax, ab;
  logic signed [36:0] vb_full;
  logic [35:0]        w1_q, wb_q;
  logic [34:0]        vb_q;

  assign ax      = x1_q[16] ? 17'(-x1_q) : 17'(x1_q);
  assign ab      = b1_q[15] ? 17'(-17'(b1_q)) : 17'(b1_q);
  assign vb_full = 37'(lr1_q) * 37'sd378194 + 37'sd12884901888;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= 17'(gate) + 17'(bias);
      a1_q   <= gate;
      b1_q   <= bin;
      lr1_q  <= lrate;
      byp1_q <= byp_q;
      w1_q   <= 36'(ax) * 36'(gdbg_pkg::LOG2E_Q18);
      wb_q   <= 36'(ab) * 36'(gdbg_pkg::LOG2E_Q18);
      vb_q   <= vb_full[34:0];
    end
  end

  // softplus path
  logic [30:0] t_dec;
  logic [24:0] ln_val;

  gdbg_exp2neg u_exp_t (.clk_i(clk_i), .en_i(en), .w_i(w1_q), .val_o(t_dec));
  gdbg_ln1p    u_ln    (.clk_i(clk_i), .en_i(en), .t_i(t_dec), .ln_o(ln_val));

  // rate path: r = 2^(log_rate*log2e), Q.24
  logic [30:0] pf;
  logic [4:0]  nbd_q [gdbg_pkg::POW_LAT];
  logic [4:0]  nb;
  logic [35:0] r_q, r_d;

  gdbg_pow2 u_rate (.clk_i(clk_i), .en_i(en), .frac_i(vb_q[29:0]), .pow_o(pf));

  assign nb  = nbd_q[gdbg_pkg::POW_LAT-1];
  assign r_d = (nb >= 5'd18) ? (36'(pf) << (nb - 5'd18)) : (36'(pf) >> (5'd18 - nb));

  // beta path
  logic [30:0]          t_beta;
  logic [gdbg_pkg::QB-1:0] sq;

  gdbg_exp2neg u_exp_b (.clk_i(clk_i), .en_i(en), .w_i(wb_q), .val_o(t_beta));
  gdbg_recip   u_div   (.clk_i(clk_i), .en_i(en), .t_i(t_beta), .q_o(sq));

  // delay lines
  logic [16:0]  xd_q    [D_X];
  logic [35:0]  rd_q    [D_R];
  logic         bigd_q  [D_BIG];
  logic         negd_q  [D_NEG];
  logic [15:0]  betad_q [D_BETA];
  logic [32:0]  bypd_q  [D_BYP];

  logic [16:0]  xs;
  logic [28:0]  sp_full;
  logic [24:0]  sp_q, sp2_q;
  logic [42:0]  plo_q;
  logic [17:0]  rhi_q;
  logic [61:0]  p_full;
  logic [41:0]  p;
  logic         big_q;
  logic [28:0]  pw_q;
  logic [59:0]  w2_full;
  logic [35:0]  w2_q;
  logic [30:0]  e;
  logic [15:0]  beta_q;
  logic [31:0]  rnd;
  logic [15:0]  dec;
  logic [32:0]  bp;
  logic [15:0]  fin_dec_q, fin_beta_q;

  assign xs      = xd_q[D_X-1];
  assign sp_full = 29'(ln_val) + ((!xs[16] && (xs != 17'd0)) ? 29'({xs[15:0], 12'd0}) : 29'd0);
  assign p_full  = ((62'(rhi_q) * 62'(sp2_q)) << 18) + 62'(plo_q);
  assign p       = p_full[61:20];
  assign w2_full = 60'(pw_q) * 60'(gdbg_pkg::LOG2E_Q30);

  gdbg_exp2neg u_exp_p (.clk_i(clk_i), .en_i(en), .w_i(w2_q), .val_o(e));

  assign rnd = 32'(e) + 32'h0002_0000;
  assign dec = bigd_q[D_BIG-1] ? 16'd0 : 16'(rnd >> 18);
  assign bp  = bypd_q[D_BYP-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      nbd_q[0] <= vb_q[34:30];
      for (int i = 1; i < gdbg_pkg::POW_LAT; i++) nbd_q[i] <= nbd_q[i-1];
      r_q <= r_d;

      xd_q[0] <= x1_q;
      for (int i = 1; i < D_X; i++) xd_q[i] <= xd_q[i-1];
      rd_q[0] <= r_q;
      for (int i = 1; i < D_R; i++) rd_q[i] <= rd_q[i-1];

      sp_q  <= sp_full[28:4];
      plo_q <= 43'(rd_q[D_R-1][17:0]) * 43'(sp_q);
      rhi_q <= rd_q[D_R-1][35:18];
      sp2_q <= sp_q;
      // exponent of 32 or more underflows to zero
      big_q <= (p[41:29] != 13'd0);
      pw_q  <= p[28:0];
      w2_q  <= w2_full[59:24];

      bigd_q[0] <= big_q;
      for (int i = 1; i < D_BIG; i++) bigd_q[i] <= bigd_q[i-1];

      negd_q[0] <= b1_q[15];
      for (int i = 1; i < D_NEG; i++) negd_q[i] <= negd_q[i-1];
      beta_q <= negd_q[D_NEG-1] ? (16'd4096 - 16'(sq)) : 16'(sq);
      betad_q[0] <= beta_q;
      for (int i = 1; i < D_BETA; i++) betad_q[i] <= betad_q[i-1];

      bypd_q[0] <= {byp1_q, b1_q, a1_q};
      for (int i = 1; i < D_BYP; i++) bypd_q[i] <= bypd_q[i-1];

      fin_dec_q  <= bp[32] ? bp[15:0]  : dec;
      fin_beta_q <= bp[32] ? bp[31:16] : betad_q[D_BETA-1];
    end
  end

  // output buffer, head in entry 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !pop) begin
      if (cnt_q == 2'd0) ob_q[0] <= {fin_beta_q, fin_dec_q};
      else ob_q[1] <= {fin_beta_q, fin_dec_q};
    end else if (pop && !push) begin
      ob_q[0] <= ob_q[1];
    end else if (pop && push) begin
      if (cnt_q == 2'd1) begin
        ob_q[0] <= {fin_beta_q, fin_dec_q};
      end else begin
        ob_q[0] <= ob_q[1];
        ob_q[1] <= {fin_beta_q, fin_dec_q};
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = ob_q[0];

  `GDBG_NEVER(a_cnt_range, cnt_q == 2'd3, "output buffer count out of range")
  `GDBG_NEVER(a_no_overflow, push && !pop && (cnt_q == 2'd2), "push into full output buffer")
  `GDBG_ASSERT(a_stall_hold, !en |=> $stable(vld_q), "pipeline moved during stall")
  `GDBG_ASSERT(a_pop_count, (pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1), "bad count on pop")

endmodule

// ===== rtl/gdbg_pow2.sv =====
`timescale 1ns / 1ps
// 2^f for f in [0,1) Q.30, one Horner step per stage
module gdbg_pow2 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [29:0] frac_i,
  output logic [30:0] pow_o
);

  logic [31:0] acc_q  [gdbg_pkg::POW_LAT];
  logic [29:0] f_q    [gdbg_pkg::POW_LAT-1];
  logic [31:0] acc_in [gdbg_pkg::POW_LAT];
  logic [29:0] f_in   [gdbg_pkg::POW_LAT];
  logic [61:0] prod   [gdbg_pkg::POW_LAT];
  logic [31:0] acc_d  [gdbg_pkg::POW_LAT];

  always_comb begin
    acc_in[0] = gdbg_pkg::PC6;
    f_in[0]   = frac_i;
    for (int k = 1; k < gdbg_pkg::POW_LAT; k++) begin
      acc_in[k] = acc_q[k-1];
      f_in[k]   = f_q[k-1];
    end
    for (int k = 0; k < gdbg_pkg::POW_LAT; k++) begin
      prod[k]  = 62'(acc_in[k]) * 62'(f_in[k]);
      acc_d[k] = gdbg_pkg::POW_ADD[k] + prod[k][61:30];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < gdbg_pkg::POW_LAT; k++) acc_q[k] <= acc_d[k];
      for (int k = 0; k < gdbg_pkg::POW_LAT - 1; k++) f_q[k] <= f_in[k];
    end
  end

  assign pow_o = acc_q[gdbg_pkg::POW_LAT-1][30:0];

endmodule

// ===== rtl/gdbg_exp2neg.sv =====
`timescale 1ns / 1ps
// 2^-w, w in Q.30; result Q.30
module gdbg_exp2neg (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [gdbg_pkg::EXP_W-1:0] w_i,
  output logic [30:0]                val_o
);

  logic [5:0]  n0_q;
  logic        fz0_q;
  logic [29:0] f0_q;
  logic [5:0]  n_q  [gdbg_pkg::POW_LAT];
  logic        fz_q [gdbg_pkg::POW_LAT];
  logic [30:0] pow;
  logic [30:0] val_q;
  logic [30:0] val_d;
  logic [5:0]  nn;
  logic [31:0] frc;

  assign frc = gdbg_pkg::ONE_Q30 - {2'b00, w_i[29:0]};

  gdbg_pow2 u_pow2 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .frac_i(f0_q),
    .pow_o (pow)
  );

  assign nn = n_q[gdbg_pkg::POW_LAT-1];

  always_comb begin
    if (fz_q[gdbg_pkg::POW_LAT-1]) begin
      val_d = (nn >= 6'd31) ? 31'd0 : 31'(gdbg_pkg::ONE_Q30 >> nn);
    end else begin
      val_d = (nn >= 6'd62) ? 31'd0 : 31'({33'd0, pow} >> (7'(nn) + 7'd1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_q  <= w_i[35:30];
      fz0_q <= (w_i[29:0] == 30'd0);
      f0_q  <= frc[29:0];
      n_q[0]  <= n0_q;
      fz_q[0] <= fz0_q;
      for (int k = 1; k < gdbg_pkg::POW_LAT; k++) begin
        n_q[k]  <= n_q[k-1];
        fz_q[k] <= fz_q[k-1];
      end
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

// ===== rtl/gdbg_ln1p.sv =====
`timescale 1ns / 1ps
// ln(1+t), t in Q.30; bit-serial log2 by repeated squaring, one bit per stage
module gdbg_ln1p (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] t_i,
  output logic [24:0] ln_o
);

  localparam int N = gdbg_pkg::LN_STEPS;

  logic [31:0] m_init;
  logic [30:0] m0_q;
  logic        ip0_q;
  logic [30:0] m_q  [N-1];
  logic [23:0] fr_q [N];
  logic        ip_q [N];
  logic [30:0] m_in  [N];
  logic [23:0] fr_in [N];
  logic [61:0] sq    [N];
  logic [30:0] m_d   [N];
  logic [23:0] fr_d  [N];
  logic [54:0] ln_full;
  logic [24:0] ln_q;

  assign m_init = gdbg_pkg::ONE_Q30 + {1'b0, t_i};

  always_comb begin
    m_in[0]  = m0_q;
    fr_in[0] = '0;
    for (int i = 1; i < N; i++) begin
      m_in[i]  = m_q[i-1];
      fr_in[i] = fr_q[i-1];
    end
    for (int i = 0; i < N; i++) begin
      sq[i]   = (62'(m_in[i]) * 62'(m_in[i])) >> 30;
      // square at or above 2.0 yields a one bit and renormalizes
      m_d[i]  = sq[i][31] ? sq[i][31:1] : sq[i][30:0];
      fr_d[i] = {fr_in[i][22:0], sq[i][31]};
    end
  end

  assign ln_full = 55'({ip_q[N-1], fr_q[N-1]}) * 55'(gdbg_pkg::LN2_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ip0_q <= m_init[31];
      m0_q  <= m_init[31] ? m_init[31:1] : m_init[30:0];
      ip_q[0] <= ip0_q;
      for (int i = 1; i < N; i++) ip_q[i] <= ip_q[i-1];
      for (int i = 0; i < N - 1; i++) m_q[i] <= m_d[i];
      for (int i = 0; i < N; i++) fr_q[i] <= fr_d[i];
      ln_q <= ln_full[54:30];
    end
  end

  assign ln_o = ln_q;

endmodule

// ===== rtl/gdbg_recip.sv =====
`timescale 1ns / 1ps
// round(2^42 / (2^30 + t)); restoring division, one quotient bit per stage
module gdbg_recip (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [30:0]             t_i,
  output logic [gdbg_pkg::QB-1:0] q_o
);

  localparam int QB = gdbg_pkg::QB;

  logic [31:0]    d_init;
  logic [31:0]    d0_q;
  logic [43:0]    r0_q;
  logic [31:0]    d_q   [QB-1];
  logic [43:0]    rem_q [QB-1];
  logic [QB-1:0]  q_q   [QB];
  logic [31:0]    d_in   [QB];
  logic [43:0]    rem_in [QB];
  logic [QB-1:0]  q_in   [QB];
  logic [43:0]    dsh    [QB];
  logic           ge     [QB];
  logic [43:0]    rem_d  [QB];

  assign d_init = gdbg_pkg::ONE_Q30 + {1'b0, t_i};

  always_comb begin
    d_in[0]   = d0_q;
    rem_in[0] = r0_q;
    q_in[0]   = '0;
    for (int k = 1; k < QB; k++) begin
      d_in[k]   = d_q[k-1];
      rem_in[k] = rem_q[k-1];
      q_in[k]   = q_q[k-1];
    end
    for (int k = 0; k < QB; k++) begin
      dsh[k]   = 44'(d_in[k]) << (QB - 1 - k);
      ge[k]    = (rem_in[k] >= dsh[k]);
      rem_d[k] = ge[k] ? (rem_in[k] - dsh[k]) : rem_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d0_q <= d_init;
      r0_q <= (44'd1 << 42) + 44'(d_init >> 1);
      for (int k = 0; k < QB - 1; k++) begin
        d_q[k]   <= d_in[k];
        rem_q[k] <= rem_d[k];
      end
      for (int k = 0; k < QB; k++) q_q[k] <= {q_in[k][QB-2:0], ge[k]};
    end
  end

  assign q_o = q_q[QB-1];

endmodule

// ===== tb/gated_decay_and_beta_gate_tb.sv =====
`timescale 1ns / 1ps
module gated_decay_and_beta_gate_tb;

  typedef struct packed {
    logic signed [15:0] log_rate;
    logic signed [15:0] time_bias;
    logic signed [15:0] beta_in;
    logic signed [15:0] gate_in;
  } gate_item_t;

  typedef struct packed {
    logic signed [15:0] beta;
    logic signed [15:0] decay;
  } gate_result_t;

  localparam int PIPE_DRAIN = 80;
  localparam int RAND_ITEMS = 1950;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  gate_item_t   pending_items[$];
  gate_result_t expected_results[$];
  logic         bypass_shadow = 1'b0;
  bit           steady = 1'b0;
  int           errors = 0;
  int           sent = 0;
  int           checked = 0;
  int           bypass_checked = 0;

  gated_decay_and_beta_gate dut (.*);

  always #5 clk_i = ~clk_i;

  // 2^f, f in Q.30 fraction
  function automatic longint unsigned exp2_fraction(longint unsigned f);
    longint unsigned acc;
    acc = 64'(gdbg_pkg::PC6);
    acc = 64'(gdbg_pkg::PC5) + ((acc * f) >> 30);
    acc = 64'(gdbg_pkg::PC4) + ((acc * f) >> 30);
    acc = 64'(gdbg_pkg::PC3) + ((acc * f) >> 30);
    acc = 64'(gdbg_pkg::PC2) + ((acc * f) >> 30);
    acc = 64'(gdbg_pkg::PC1) + ((acc * f) >> 30);
    return 64'h4000_0000 + ((acc * f) >> 30);
  endfunction

  // 2^-w, w in Q.30
  function automatic longint unsigned exp2_negative(longint unsigned w);
    longint unsigned n, fr;
    n = w >> 30;
    fr = w & 64'h3FFF_FFFF;
    if (n >= 62) return 0;
    if (fr == 0) return (n >= 31) ? 0 : (64'h4000_0000 >> n);
    return exp2_fraction(64'h4000_0000 - fr) >> (n + 1);
  endfunction

  // ln(1+t) by bitwise binary log, Q.24 result
  function automatic longint unsigned log_one_plus(longint unsigned t);
    longint unsigned m, ip, frac;
    m = 64'h4000_0000 + t;
    ip = 0;
    frac = 0;
    if (m >= 64'h8000_0000) begin
      ip = 1;
      m = m >> 1;
    end
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (((ip << 24) | frac) * longint'(gdbg_pkg::LN2_Q30)) >> 30;
  endfunction

  function automatic longint unsigned abs_value(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic [15:0] saturate16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint decay_of(longint a, longint bias, longint lr);
    longint x;
    longint unsigned t, sp, vb, nb, pf, r, p, w;
    x = a + bias;
    if (x < -65536) x = -65536;
    if (x > 65535) x = 65535;
    t = exp2_negative(abs_value(x) * longint'(gdbg_pkg::LOG2E_Q18));
    sp = log_one_plus(t);
    if (x > 0) sp = sp + (longint'(x) << 12);
    sp = sp >> 4;
    vb = lr * longint'(gdbg_pkg::LOG2E_Q18) + 64'd12 * 64'h4000_0000;
    nb = vb >> 30;
    pf = exp2_fraction(vb & 64'h3FFF_FFFF);
    r = (nb >= 18) ? (pf << (nb - 18)) : (pf >> (18 - nb));
    p = (r * sp) >> 20;
    if (p >= (64'd32 << 24)) return 0;
    w = (p * longint'(gdbg_pkg::LOG2E_Q30)) >> 24;
    return longint'((exp2_negative(w) + (64'd1 << 17)) >> 18);
  endfunction

  function automatic longint sigmoid_of(longint b);
    longint unsigned t, d, s;
    t = exp2_negative(abs_value(b) * longint'(gdbg_pkg::LOG2E_Q18));
    d = 64'h4000_0000 + t;
    s = ((64'd1 << 42) + (d >> 1)) / d;
    return (b >= 0) ? longint'(s) : 4096 - longint'(s);
  endfunction

  function automatic gate_result_t predict_gates(gate_item_t it, logic bypass);
    gate_result_t res;
    if (bypass) begin
      res.decay = it.gate_in;
      res.beta  = it.beta_in;
    end else begin
      res.decay = saturate16(decay_of(it.gate_in, it.time_bias, it.log_rate));
      res.beta  = saturate16(sigmoid_of(it.beta_in));
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 16384)) - 8192);
      2: return 16'($signed($urandom_range(0, 2048)) - 1024);
      default: return $urandom_range(0, 1) ? 16'(16'h7FFF - $urandom_range(0, 15))
                                             : 16'(16'h8000 + $urandom_range(0, 15));
    endcase
  endfunction

  task automatic add_item(logic [15:0] g, logic [15:0] b, logic [15:0] tb_, logic [15:0] lr);
    gate_item_t it;
    it.gate_in = g;
    it.beta_in = b;
    it.time_bias = tb_;
    it.log_rate = lr;
    pending_items.push_back(it);
  endtask

  task automatic add_directed();
    add_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF); // large exponent, decay 0
    add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_item(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    add_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    add_item(16'h0001, 16'h0001, 16'h0000, 16'h0000);
    add_item(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    add_item(16'h1000, 16'hF000, 16'h0000, 16'h1000);
    add_item(16'hF000, 16'h1000, 16'h1000, 16'hF000);
    add_item(16'h4000, 16'hC000, 16'hC000, 16'h0000); // x exactly zero
    add_item(16'h0800, 16'h5555, 16'h0000, 16'hAAAA);
    add_item(16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555);
    add_item(16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA);
    add_item(16'h2000, 16'h0100, 16'h2000, 16'h2000);
  endtask

  task automatic write_bypass(logic v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    bypass_shadow <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    gate_item_t nxt;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(predict_gates(gate_item_t'(s_axis_tdata), bypass_shadow));
      sent++;
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 32)) begin
        nxt = pending_items.pop_front();
        s_axis_tdata <= nxt;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    gate_result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.decay !== want.decay) begin
          $error("decay: expected %0d, got %0d", want.decay, got.decay);
          errors++;
        end
        if (got.beta !== want.beta) begin
          $error("beta: expected %0d, got %0d", want.beta, got.beta);
          errors++;
        end
        checked++;
        if (bypass_shadow) bypass_checked++;
      end
    end
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 32);
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    add_directed();
    drain();
    write_bypass(1'b1);
    add_directed();
    for (int i = 0; i < 150; i++) add_item(pick_value(), pick_value(), pick_value(), pick_value());
    drain();
    write_bypass(1'b0);
    for (int i = 0; i < RAND_ITEMS - 150; i++) begin
      add_item(pick_value(), pick_value(), pick_value(), pick_value());
      if (i == 600) begin
        // stretch with no idling on either side
        while (pending_items.size() > 400) @(posedge clk_i);
        steady = 1'b1;
        while (pending_items.size() > 0) @(posedge clk_i);
        steady = 1'b0;
      end
    end
    drain();
    write_bypass(1'b1);
    write_bypass(1'b0);
    add_directed();
    drain();

    $display("Checked %0d results (%0d in bypass) over %0d transfers, bypass on and off.",
             checked, bypass_checked, sent);
    if (errors == 0 && expected_results.size() == 0)
      $display("gated_decay_and_beta_gate: match");
    else
      $display("gated_decay_and_beta_gate: mismatch");
    $finish;
  end

  initial begin
    #2ms;
    $display("gated_decay_and_beta_gate: mismatch");
    $finish;
  end

endmodule

// ===== gated_decay_and_beta_gate.f =====
+incdir+rtl
rtl/gdbg_pkg.sv
rtl/gdbg_pow2.sv
rtl/gdbg_exp2neg.sv
rtl/gdbg_ln1p.sv
rtl/gdbg_recip.sv
rtl/gated_decay_and_beta_gate.sv
tb/gated_decay_and_beta_gate_tb.sv
